/* design/rvdec_pkg.sv */
// Package for the RV32IM instruction decoder: word types, opcode constants,
// operation class and operation code enumerations. No dependencies.
package rvdec_pkg;

  localparam logic [31:0] NopWord = 32'h0000_0013;
  localparam logic [11:0] CsrMepc = 12'h341;
  localparam logic [11:0] FnMret  = 12'h302;
  localparam logic [11:0] FnWfi   = 12'h105;
  localparam logic [11:0] FnEcall = 12'h000;
  localparam logic [11:0] FnEbrk  = 12'h001;
  localparam logic [6:0]  F7Zero  = 7'h00;
  localparam logic [6:0]  F7Alt   = 7'h20;
  localparam logic [6:0]  F7Mul   = 7'h01;
  localparam logic [4:0]  RegRa   = 5'd1;
  localparam logic [4:0]  RegT0   = 5'd5;

  localparam logic [6:0] OpcOpImm  = 7'h13;
  localparam logic [6:0] OpcOp     = 7'h33;
  localparam logic [6:0] OpcLoad   = 7'h03;
  localparam logic [6:0] OpcStore  = 7'h23;
  localparam logic [6:0] OpcLui    = 7'h37;
  localparam logic [6:0] OpcAuipc  = 7'h17;
  localparam logic [6:0] OpcJal    = 7'h6f;
  localparam logic [6:0] OpcJalr   = 7'h67;
  localparam logic [6:0] OpcBranch = 7'h63;
  localparam logic [6:0] OpcMiscMm = 7'h0f;
  localparam logic [6:0] OpcSystem = 7'h73;

  typedef enum logic [3:0] {
    OC_OPIMM   = 4'd0,
    OC_OP      = 4'd1,
    OC_LOAD    = 4'd2,
    OC_STORE   = 4'd3,
    OC_LUI     = 4'd4,
    OC_AUIPC   = 4'd5,
    OC_JAL     = 4'd6,
    OC_JALR    = 4'd7,
    OC_BRANCH  = 4'd8,
    OC_MISCMEM = 4'd9,
    OC_SYSTEM  = 4'd10,
    OC_UNKNOWN = 4'd11
  } op_class_e;

  typedef enum logic [5:0] {
    OP_NONE   = 6'd0,
    OP_ADD    = 6'd1,
    OP_SUB    = 6'd2,
    OP_MUL    = 6'd3,
    OP_MULH   = 6'd4,
    OP_SLL    = 6'd5,
    OP_MULHSU = 6'd6,
    OP_SLT    = 6'd7,
    OP_MULHU  = 6'd8,
    OP_SLTU   = 6'd9,
    OP_DIV    = 6'd10,
    OP_XOR    = 6'd11,
    OP_DIVU   = 6'd12,
    OP_SRA    = 6'd13,
    OP_SRL    = 6'd14,
    OP_REM    = 6'd15,
    OP_OR     = 6'd16,
    OP_REMU   = 6'd17,
    OP_AND    = 6'd18,
    OP_BEQ    = 6'd19,
    OP_BNE    = 6'd20,
    OP_BLT    = 6'd21,
    OP_BGE    = 6'd22,
    OP_BLTU   = 6'd23,
    OP_BGEU   = 6'd24,
    OP_LB     = 6'd25,
    OP_LH     = 6'd26,
    OP_LW     = 6'd27,
    OP_LBU    = 6'd28,
    OP_LHU    = 6'd29,
    OP_SB     = 6'd30,
    OP_SH     = 6'd31,
    OP_SW     = 6'd32,
    OP_ECALL  = 6'd33,
    OP_EBREAK = 6'd34,
    OP_MRET   = 6'd35,
    OP_WFI    = 6'd36,
    OP_CSRRW  = 6'd37,
    OP_CSRRS  = 6'd38,
    OP_CSRRC  = 6'd39,
    OP_CSRRWI = 6'd40,
    OP_CSRRSI = 6'd41,
    OP_CSRRCI = 6'd42
  } operation_e;

  typedef struct packed {
    logic [31:0] instr_word;
    logic        flush;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         op_class;
    logic [5:0]         operation;
    logic signed [31:0] immediate;
    logic [4:0]         src1_index;
    logic [4:0]         src2_index;
    logic [4:0]         dest_index;
    logic [2:0]         register_use;
    logic [1:0]         csr_access;
    logic [11:0]        csr_address;
    logic               ras_push;
    logic               illegal;
  } out_word_t;

endpackage

/* design/rv32im_instruction_decoder.sv */
// Top level of the RV32IM instruction decoder: input register, decode, result register.
// Depends on rvdec_pkg and rvdec_core.
//
// Usage:
// The input channel (in_valid_i, in_ready_o, in_data_i) takes one word per
// accepted handshake: a 32-bit instruction and a flush flag that replaces the
// instruction with the canonical NOP. The output channel (out_valid_o,
// out_ready_i, out_data_o) gives one decoded word per input word, in order.
// A word accepted at a clock edge is captured in the input register, is
// decoded combinationally from it and is written to the result register at
// the next edge at which that register is free or being emptied; its result
// is offered from then on until the receiver takes it.
// Throughput is one word per cycle; both registers advance together whenever
// the result register is free or being emptied, which sets that figure.
// When the receiver stalls, the result register holds its word, the input
// register holds the word behind it, and in_ready_o drops once both are full.
// Reset empties both registers; no result is offered until a new word arrives.
module rv32im_instruction_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rvdec_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rvdec_pkg::out_word_t out_data_o
);
  import rvdec_pkg::*;

  in_word_t  s1_q;
  logic      s1_valid_q, s1_valid_d;
  out_word_t dec_word;
  out_word_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      out_free, s1_adv, in_acc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (s1_adv) begin
      out_q <= dec_word;
    end
  end

  rvdec_core u_core (
    .in_word_i  (s1_q),
    .out_word_o (dec_word)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("input register lost or changed a stalled word");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a word in the input register");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("empty input register refused a word");

  a_illegal_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.illegal) |-> (out_q.operation == OP_NONE))
    else $error("illegal word carries an operation");

  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.op_class == OC_UNKNOWN) |->
      (out_q.illegal && out_q.register_use == 3'd0 && out_q.csr_access == 2'd0))
    else $error("unknown opcode decoded with side effects");

endmodule

/* design/rvdec_core.sv */
// Combinational decode of one RV32IM instruction word into a result word.
// Depends on rvdec_pkg for types, opcodes and operation codes.
module rvdec_core (
  input  rvdec_pkg::in_word_t  in_word_i,
  output rvdec_pkg::out_word_t out_word_o
);
  import rvdec_pkg::*;

  logic [31:0] w;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rsa, rsb, rdn;
  logic [11:0] i12;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic        r1, r2, rw, z7, s7, m7, clean, push_rd;

  assign w     = in_word_i.flush ? NopWord : in_word_i.instr_word;
  assign opc   = w[6:0];
  assign f3    = w[14:12];
  assign f7    = w[31:25];
  assign rsa   = w[19:15];
  assign rsb   = w[24:20];
  assign rdn   = w[11:7];
  assign i12   = w[31:20];
  assign imm_i = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_u = {w[31:12], 12'b0};
  assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign r1    = rsa != 5'd0;
  assign r2    = rsb != 5'd0;
  assign rw    = rdn != 5'd0;
  assign z7    = f7 == F7Zero;
  assign s7    = f7 == F7Alt;
  assign m7    = f7 == F7Mul;
  assign clean = !r1 && !rw;
  assign push_rd = (rdn == RegRa) || (rdn == RegT0);

  always_comb begin
    op_class_e  cls;
    operation_e op;
    logic [31:0] imm;
    logic [2:0]  use_bits;
    logic [1:0]  csr;
    logic [11:0] csra;
    logic        ill;
    logic        push;
    cls      = OC_UNKNOWN;
    op       = OP_NONE;
    imm      = 32'd0;
    use_bits = 3'd0;
    csr      = 2'd0;
    csra     = i12;
    ill      = 1'b0;
    push     = 1'b0;
    case (opc)
      OpcOpImm: begin
        cls      = OC_OPIMM;
        imm      = imm_i;
        use_bits = {rw, 1'b0, r1};
        case (f3)
          3'd0: op = OP_ADD;
          3'd1: begin
            if (z7) op = OP_SLL;
            else ill = 1'b1;
          end
          3'd2: op = OP_SLT;
          3'd3: op = OP_SLTU;
          3'd4: op = OP_XOR;
          3'd5: begin
            if (z7) op = OP_SRL;
            else if (s7) op = OP_SRA;
            else ill = 1'b1;
          end
          3'd6: op = OP_OR;
          default: op = OP_AND;
        endcase
      end
      OpcOp: begin
        cls      = OC_OP;
        use_bits = {rw, r2, r1};
        if (z7) begin
          case (f3)
            3'd0: op = OP_ADD;
            3'd1: op = OP_SLL;
            3'd2: op = OP_SLT;
            3'd3: op = OP_SLTU;
            3'd4: op = OP_XOR;
            3'd5: op = OP_SRL;
            3'd6: op = OP_OR;
            default: op = OP_AND;
          endcase
        end else if (m7) begin
          case (f3)
            3'd0: op = OP_MUL;
            3'd1: op = OP_MULH;
            3'd2: op = OP_MULHSU;
            3'd3: op = OP_MULHU;
            3'd4: op = OP_DIV;
            3'd5: op = OP_DIVU;
            3'd6: op = OP_REM;
            default: op = OP_REMU;
          endcase
        end else if (s7 && f3 == 3'd0) begin
          op = OP_SUB;
        end else if (s7 && f3 == 3'd5) begin
          op = OP_SRA;
        end else begin
          ill = 1'b1;
        end
      end
      OpcLoad: begin
        cls      = OC_LOAD;
        imm      = imm_i;
        use_bits = {rw, 1'b0, r1};
        case (f3)
          3'd0: op = OP_LB;
          3'd1: op = OP_LH;
          3'd2: op = OP_LW;
          3'd4: op = OP_LBU;
          3'd5: op = OP_LHU;
          default: ill = 1'b1;
        endcase
      end
      OpcStore: begin
        cls      = OC_STORE;
        imm      = imm_s;
        use_bits = {1'b0, r2, r1};
        case (f3)
          3'd0: op = OP_SB;
          3'd1: op = OP_SH;
          3'd2: op = OP_SW;
          default: ill = 1'b1;
        endcase
      end
      OpcLui: begin
        cls      = OC_LUI;
        imm      = imm_u;
        use_bits = {rw, 2'b00};
      end
      OpcAuipc: begin
        cls      = OC_AUIPC;
        imm      = imm_u;
        use_bits = {rw, 2'b00};
      end
      OpcJal: begin
        cls      = OC_JAL;
        imm      = imm_j;
        use_bits = {rw, 2'b00};
        push     = push_rd;
      end
      OpcJalr: begin
        cls      = OC_JALR;
        imm      = imm_i;
        use_bits = {rw, 1'b0, r1};
        push     = push_rd;
        ill      = f3 != 3'd0;
      end
      OpcBranch: begin
        cls      = OC_BRANCH;
        imm      = imm_b;
        use_bits = {1'b0, r2, r1};
        case (f3)
          3'd0: op = OP_BEQ;
          3'd1: op = OP_BNE;
          3'd4: op = OP_BLT;
          3'd5: op = OP_BGE;
          3'd6: op = OP_BLTU;
          3'd7: op = OP_BGEU;
          default: ill = 1'b1;
        endcase
      end
      OpcMiscMm: begin
        cls = OC_MISCMEM;
      end
      OpcSystem: begin
        cls      = OC_SYSTEM;
        use_bits = {rw, 2'b00};
        case (f3)
          3'd0: begin
            if (clean && i12 == FnEcall) begin
              op = OP_ECALL;
            end else if (clean && i12 == FnEbrk) begin
              op = OP_EBREAK;
            end else if (clean && i12 == FnMret) begin
              op   = OP_MRET;
              csra = CsrMepc;
              csr  = 2'b01;
            end else if (clean && i12 == FnWfi) begin
              op = OP_WFI;
            end else begin
              ill = 1'b1;
            end
          end
          3'd4: ill = 1'b1;
          default: begin
            case (f3)
              3'd1: op = OP_CSRRW;
              3'd2: op = OP_CSRRS;
              3'd3: op = OP_CSRRC;
              3'd5: op = OP_CSRRWI;
              3'd6: op = OP_CSRRSI;
              default: op = OP_CSRRCI;
            endcase
            use_bits[0] = !f3[2] && r1;
            csr[0]      = rw;
            csr[1]      = (f3[1:0] == 2'b01) || r1;
          end
        endcase
      end
      default: ill = 1'b1;
    endcase
    out_word_o.op_class     = cls;
    out_word_o.operation    = op;
    out_word_o.immediate    = imm;
    out_word_o.src1_index   = rsa;
    out_word_o.src2_index   = rsb;
    out_word_o.dest_index   = rdn;
    out_word_o.register_use = use_bits;
    out_word_o.csr_access   = csr;
    out_word_o.csr_address  = csra;
    out_word_o.ras_push     = push;
    out_word_o.illegal      = ill;
  end

endmodule

/* dv/rv32im_instruction_decoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rv32im_instruction_decoder. It predicts every decoded word
// and compares it field by field, under random gaps, stalls and a long output hold-off.
// Depends on rvdec_pkg and the decoder RTL; it needs no files or arguments.
module rv32im_instruction_decoder_tb;
  import rvdec_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int HoldCycles = 80;
  localparam int PhaseWords = 265;
  localparam logic [2:0] F3Base = 3'd0;
  localparam logic [2:0] UseRs1 = 3'b001;
  localparam logic [2:0] UseRs2 = 3'b010;
  localparam logic [2:0] UseRd = 3'b100;
  localparam logic [1:0] CsrRd = 2'b01;
  localparam logic [1:0] CsrWr = 2'b10;

  typedef struct {
    in_word_t  stim;
    out_word_t want;
  } decode_check_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_word_t in_data = '0;
  logic out_ready = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_word_t out_data_o;

  logic calm = 1'b0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int in_stall_cycles = 0;
  int errors = 0;
  int words_sent = 0;
  int words_flushed = 0;
  int words_checked = 0;
  int illegal_seen = 0;
  int ras_seen = 0;
  logic [63:0] ops_seen = '0;
  decode_check_t pending[$];

  operation_e alu_by_f3 [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_OR, OP_AND};
  operation_e muldiv_by_f3 [8] = '{OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
                                   OP_DIV, OP_DIVU, OP_REM, OP_REMU};
  operation_e load_by_f3 [8] = '{OP_LB, OP_LH, OP_LW, OP_NONE,
                                 OP_LBU, OP_LHU, OP_NONE, OP_NONE};
  operation_e store_by_f3 [8] = '{OP_SB, OP_SH, OP_SW, OP_NONE,
                                  OP_NONE, OP_NONE, OP_NONE, OP_NONE};
  operation_e branch_by_f3 [8] = '{OP_BEQ, OP_BNE, OP_NONE, OP_NONE,
                                   OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};
  operation_e csr_by_f3 [8] = '{OP_NONE, OP_CSRRW, OP_CSRRS, OP_CSRRC,
                                OP_NONE, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI};
  logic [6:0] known_opcodes [11] = '{OpcOpImm, OpcOp, OpcLoad, OpcStore, OpcLui, OpcAuipc,
                                     OpcJal, OpcJalr, OpcBranch, OpcMiscMm, OpcSystem};

  rv32im_instruction_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic out_word_t decode_expected(in_word_t stim);
    logic [31:0] iw;
    logic [6:0] f7;
    logic [2:0] f3;
    logic [4:0] rs1, rs2, rd;
    logic [11:0] i12;
    logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
    logic [2:0] rs1_use, rs2_use, rd_use;
    out_word_t o;
    iw = stim.flush ? NopWord : stim.instr_word;
    f7 = iw[31:25];
    f3 = iw[14:12];
    rs1 = iw[19:15];
    rs2 = iw[24:20];
    rd = iw[11:7];
    i12 = iw[31:20];
    imm_i = {{20{iw[31]}}, iw[31:20]};
    imm_s = {{20{iw[31]}}, iw[31:25], iw[11:7]};
    imm_b = {{19{iw[31]}}, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0};
    imm_u = {iw[31:12], 12'h000};
    imm_j = {{11{iw[31]}}, iw[31], iw[19:12], iw[20], iw[30:21], 1'b0};
    rs1_use = (rs1 != 5'd0) ? UseRs1 : 3'b000;
    rs2_use = (rs2 != 5'd0) ? UseRs2 : 3'b000;
    rd_use = (rd != 5'd0) ? UseRd : 3'b000;
    o = '0;
    o.op_class = OC_UNKNOWN;
    o.operation = OP_NONE;
    o.src1_index = rs1;
    o.src2_index = rs2;
    o.dest_index = rd;
    o.csr_address = i12;
    case (iw[6:0])
      OpcOpImm: begin
        o.op_class = OC_OPIMM;
        o.immediate = imm_i;
        o.register_use = rs1_use | rd_use;
        if (alu_by_f3[f3] == OP_SLL) begin
          if (f7 == F7Zero) o.operation = OP_SLL;
          else o.illegal = 1'b1;
        end else if (alu_by_f3[f3] == OP_SRL) begin
          if (f7 == F7Zero) o.operation = OP_SRL;
          else if (f7 == F7Alt) o.operation = OP_SRA;
          else o.illegal = 1'b1;
        end else begin
          o.operation = alu_by_f3[f3];
        end
      end
      OpcOp: begin
        o.op_class = OC_OP;
        o.register_use = rs1_use | rs2_use | rd_use;
        if (f7 == F7Zero) o.operation = alu_by_f3[f3];
        else if (f7 == F7Mul) o.operation = muldiv_by_f3[f3];
        else if (f7 == F7Alt && alu_by_f3[f3] == OP_ADD) o.operation = OP_SUB;
        else if (f7 == F7Alt && alu_by_f3[f3] == OP_SRL) o.operation = OP_SRA;
        else o.illegal = 1'b1;
      end
      OpcLoad: begin
        o.op_class = OC_LOAD;
        o.immediate = imm_i;
        o.register_use = rs1_use | rd_use;
        o.operation = load_by_f3[f3];
        o.illegal = load_by_f3[f3] == OP_NONE;
      end
      OpcStore: begin
        o.op_class = OC_STORE;
        o.immediate = imm_s;
        o.register_use = rs1_use | rs2_use;
        o.operation = store_by_f3[f3];
        o.illegal = store_by_f3[f3] == OP_NONE;
      end
      OpcLui: begin
        o.op_class = OC_LUI;
        o.immediate = imm_u;
        o.register_use = rd_use;
      end
      OpcAuipc: begin
        o.op_class = OC_AUIPC;
        o.immediate = imm_u;
        o.register_use = rd_use;
      end
      OpcJal: begin
        o.op_class = OC_JAL;
        o.immediate = imm_j;
        o.register_use = rd_use;
        o.ras_push = rd == RegRa || rd == RegT0;
      end
      OpcJalr: begin
        o.op_class = OC_JALR;
        o.immediate = imm_i;
        o.register_use = rs1_use | rd_use;
        o.ras_push = rd == RegRa || rd == RegT0;
        o.illegal = f3 != F3Base;
      end
      OpcBranch: begin
        o.op_class = OC_BRANCH;
        o.immediate = imm_b;
        o.register_use = rs1_use | rs2_use;
        o.operation = branch_by_f3[f3];
        o.illegal = branch_by_f3[f3] == OP_NONE;
      end
      OpcMiscMm: begin
        o.op_class = OC_MISCMEM;
      end
      OpcSystem: begin
        o.op_class = OC_SYSTEM;
        o.register_use = rd_use;
        if (f3 == F3Base) begin
          if (rs1 != 5'd0 || rd != 5'd0) begin
            o.illegal = 1'b1;
          end else begin
            case (i12)
              FnEcall: o.operation = OP_ECALL;
              FnEbrk: o.operation = OP_EBREAK;
              FnMret: begin
                o.operation = OP_MRET;
                o.csr_address = CsrMepc;
                o.csr_access = CsrRd;
              end
              FnWfi: o.operation = OP_WFI;
              default: o.illegal = 1'b1;
            endcase
          end
        end else if (csr_by_f3[f3] == OP_NONE) begin
          o.illegal = 1'b1;
        end else begin
          o.operation = csr_by_f3[f3];
          if ((o.operation == OP_CSRRW || o.operation == OP_CSRRS || o.operation == OP_CSRRC)
              && rs1 != 5'd0) o.register_use = o.register_use | UseRs1;
          if (rd != 5'd0) o.csr_access = o.csr_access | CsrRd;
          if (o.operation == OP_CSRRW || o.operation == OP_CSRRWI || rs1 != 5'd0)
            o.csr_access = o.csr_access | CsrWr;
        end
      end
      default: begin
        o.illegal = 1'b1;
      end
    endcase
    return o;
  endfunction

  function automatic logic [31:0] legal_word(operation_e op);
    logic [31:0] w;
    logic pick_imm;
    operation_e base;
    w = $urandom();
    pick_imm = $urandom_range(0, 1);
    base = op;
    if (op == OP_SUB) base = OP_ADD;
    if (op == OP_SRA) base = OP_SRL;
    case ($urandom_range(0, 7))
      0: w[11:7] = 5'd0;
      1: w[11:7] = RegRa;
      2: w[11:7] = RegT0;
      3: w[19:15] = 5'd0;
      4: w[24:20] = 5'd0;
      default: ;
    endcase
    if (op != OP_NONE) begin
      for (int k = 0; k < 8; k++) begin
        if (alu_by_f3[k] == base) begin
          w[14:12] = 3'(k);
          w[6:0] = pick_imm ? OpcOpImm : OpcOp;
          if (!pick_imm || base == OP_SLL || base == OP_SRL) w[31:25] = F7Zero;
        end
        if (muldiv_by_f3[k] == op) begin
          w[14:12] = 3'(k);
          w[6:0] = OpcOp;
          w[31:25] = F7Mul;
        end
        if (load_by_f3[k] == op) {w[14:12], w[6:0]} = {3'(k), OpcLoad};
        if (store_by_f3[k] == op) {w[14:12], w[6:0]} = {3'(k), OpcStore};
        if (branch_by_f3[k] == op) {w[14:12], w[6:0]} = {3'(k), OpcBranch};
        if (csr_by_f3[k] == op) {w[14:12], w[6:0]} = {3'(k), OpcSystem};
      end
    end
    case (op)
      OP_SUB: {w[31:25], w[6:0]} = {F7Alt, OpcOp};
      OP_SRA: w[31:25] = F7Alt;
      OP_ECALL: w = {FnEcall, 5'd0, F3Base, 5'd0, OpcSystem};
      OP_EBREAK: w = {FnEbrk, 5'd0, F3Base, 5'd0, OpcSystem};
      OP_MRET: w = {FnMret, 5'd0, F3Base, 5'd0, OpcSystem};
      OP_WFI: w = {FnWfi, 5'd0, F3Base, 5'd0, OpcSystem};
      OP_NONE: begin
        case ($urandom_range(0, 4))
          0: w[6:0] = OpcLui;
          1: w[6:0] = OpcAuipc;
          2: w[6:0] = OpcJal;
          3: {w[14:12], w[6:0]} = {F3Base, OpcJalr};
          default: w[6:0] = OpcMiscMm;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_word(input logic [31:0] iw, input logic fl);
    int gap;
    in_word_t w;
    decode_check_t c;
    gap = calm ? 0 : pick_gap();
    w.instr_word = iw;
    w.flush = fl;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk_i); while (!in_ready_o);
    c.stim = w;
    c.want = decode_expected(w);
    pending.push_back(c);
    words_sent++;
    if (fl) words_flushed++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending.size() != 0);
  endtask

  task automatic field_check(input string name, input in_word_t stim,
                             input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 100)
        $display("%0t ns: %s mismatch for instr %h flush %b: expected %0h, actual %0h",
                 $time, name, stim.instr_word, stim.flush, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    decode_check_t c;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t ns: decoded word %h arrived with nothing pending", $time, out_data_o);
      end else begin
        c = pending.pop_front();
        words_checked++;
        field_check("op_class", c.stim, 32'(c.want.op_class),
                    32'(out_data_o.op_class));
        field_check("operation", c.stim, 32'(c.want.operation),
                    32'(out_data_o.operation));
        field_check("immediate", c.stim, c.want.immediate, out_data_o.immediate);
        field_check("src1_index", c.stim, 32'(c.want.src1_index),
                    32'(out_data_o.src1_index));
        field_check("src2_index", c.stim, 32'(c.want.src2_index),
                    32'(out_data_o.src2_index));
        field_check("dest_index", c.stim, 32'(c.want.dest_index),
                    32'(out_data_o.dest_index));
        field_check("register_use", c.stim, 32'(c.want.register_use),
                    32'(out_data_o.register_use));
        field_check("csr_access", c.stim, 32'(c.want.csr_access),
                    32'(out_data_o.csr_access));
        field_check("csr_address", c.stim, 32'(c.want.csr_address),
                    32'(out_data_o.csr_address));
        field_check("ras_push", c.stim, 32'(c.want.ras_push),
                    32'(out_data_o.ras_push));
        field_check("illegal", c.stim, 32'(c.want.illegal),
                    32'(out_data_o.illegal));
        ops_seen[c.want.operation] = 1'b1;
        if (c.want.illegal) illegal_seen++;
        if (c.want.ras_push) ras_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (in_valid && !in_ready_o) in_stall_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t ns: no word moved for %0d cycles, %0d still pending",
               $time, idle_cycles, pending.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_field_extremes();
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'hffff_ffff, 1'b1);
    send_word(32'h0000_0000, 1'b1);
    send_word(NopWord, 1'b0);
    send_word({12'h7ff, 5'd31, F3Base, 5'd31, OpcOpImm}, 1'b0);
    send_word({12'h800, 5'd1, F3Base, 5'd1, OpcOpImm}, 1'b0);
    send_word({20'hfffff, 5'd31, OpcLui}, 1'b0);
    send_word({20'h80000, 5'd0, OpcAuipc}, 1'b0);
    send_word({20'hfffff, RegRa, OpcJal}, 1'b0);
    send_word({1'b0, 10'h3ff, 1'b1, 8'hff, RegT0, OpcJal}, 1'b0);
    send_word({1'b1, 6'h00, 5'd31, 5'd31, 3'b111, 4'h0, 1'b0, OpcBranch}, 1'b0);
    send_word({7'h3f, 5'd31, 5'd31, 3'b010, 5'h1f, OpcStore}, 1'b0);
    send_word({12'hfff, 5'd31, 3'b001, 5'd31, OpcSystem}, 1'b0);
  endtask

  task automatic test_every_operation();
    for (int k = 0; k <= int'(OP_CSRRCI); k++) send_word(legal_word(operation_e'(k)), 1'b0);
  endtask

  task automatic test_special_cases();
    send_word({F7Alt, 5'd3, 5'd2, 3'b001, 5'd1, OpcOpImm}, 1'b0);
    send_word({F7Mul, 5'd31, 5'd2, 3'b101, 5'd1, OpcOpImm}, 1'b0);
    send_word({F7Alt, 5'd4, 5'd5, 3'b100, 5'd6, OpcOp}, 1'b0);
    send_word({7'h7f, 5'd4, 5'd5, 3'b000, 5'd6, OpcOp}, 1'b0);
    send_word({12'h123, 5'd7, 3'b011, 5'd8, OpcLoad}, 1'b0);
    send_word({12'h123, 5'd7, 3'b111, 5'd8, OpcLoad}, 1'b0);
    send_word({7'h12, 5'd9, 5'd7, 3'b011, 5'd8, OpcStore}, 1'b0);
    send_word({7'h12, 5'd9, 5'd7, 3'b010, 5'd8, OpcBranch}, 1'b0);
    send_word({7'h12, 5'd9, 5'd7, 3'b011, 5'd8, OpcBranch}, 1'b0);
    send_word({12'h123, 5'd4, 3'b010, RegRa, OpcJalr}, 1'b0);
    send_word({12'h800, 5'd0, F3Base, RegT0, OpcJalr}, 1'b0);
    send_word({12'hfff, 5'd31, 3'b111, 5'd31, OpcMiscMm}, 1'b0);
    send_word({FnEcall, 5'd0, F3Base, 5'd3, OpcSystem}, 1'b0);
    send_word({FnMret, 5'd1, F3Base, 5'd0, OpcSystem}, 1'b0);
    send_word({12'h7ff, 5'd0, F3Base, 5'd0, OpcSystem}, 1'b0);
    send_word({12'h300, 5'd7, 3'b100, 5'd7, OpcSystem}, 1'b0);
    send_word({12'h300, 5'd0, 3'b010, 5'd0, OpcSystem}, 1'b0);
    send_word({12'h341, 5'd9, 3'b111, 5'd0, OpcSystem}, 1'b0);
    send_word({12'h305, 5'd0, 3'b101, 5'd0, OpcSystem}, 1'b0);
    send_word({25'h1abcdef, 7'h5b}, 1'b0);
    send_word({20'h12345, RegRa, OpcJal}, 1'b1);
  endtask

  task automatic test_backpressure();
    calm <= 1'b1;
    hold_seq <= hold_seq + 1;
    repeat (40) send_word(legal_word(operation_e'($urandom_range(0, OP_CSRRCI))), 1'b0);
    wait_drained();
    calm <= 1'b0;
  endtask

  task automatic test_random_stream();
    int r;
    int flip;
    logic [31:0] iw;
    logic fl;
    for (int phase = 0; phase < 6; phase++) begin
      calm <= (phase == 1 || phase == 4);
      for (int k = 0; k < PhaseWords; k++) begin
        r = $urandom_range(0, 99);
        fl = 1'b0;
        iw = legal_word(operation_e'($urandom_range(0, OP_CSRRCI)));
        if (r >= 60 && r < 72) begin
          flip = $urandom_range(7, 31);
          iw[flip] = ~iw[flip];
        end else if (r >= 72 && r < 80) begin
          iw = $urandom();
          iw[6:0] = known_opcodes[$urandom_range(0, 10)];
        end else if (r >= 80 && r < 88) begin
          iw = $urandom();
          fl = 1'b1;
        end else if (r >= 88) begin
          iw = $urandom();
        end
        send_word(iw, fl);
      end
      if (phase == 2) wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    test_field_extremes();
    test_every_operation();
    test_special_cases();
    test_backpressure();
    test_random_stream();
    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Decoded %0d words (%0d flushed to NOP): %0d distinct operation codes, %0d illegal,",
             words_checked, words_flushed, $countones(ops_seen), illegal_seen);
    $display("%0d return-address pushes; input held off %0d cycles; %0d field mismatches.",
             ras_seen, in_stall_cycles, errors);
    if (errors == 0 && words_checked == words_sent) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/rvdec_pkg.sv
design/rvdec_core.sv
design/rv32im_instruction_decoder.sv
dv/rv32im_instruction_decoder_tb.sv
